FILE: design/pca_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the polar complex ALU.
`timescale 1ns / 1ps

package pca_pkg;

    // Field widths.
    localparam int MAG_W = 24;
    localparam int ANG_W = 16;

    // Cartesian values carry extra fraction bits over the magnitude format.
    localparam int FRAME_GUARD = 8;

    // Datapath widths: rotation output, vectoring datapath, CORDIC angle.
    localparam int XW = 36;
    localparam int VW = 38;
    localparam int ZW = 34;

    // Number of entries in the arctangent table.
    localparam int ATAN_N = 24;

    // CORDIC gain correction, 0.60725 in Q0.30.
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    // Magnitude saturation limits.
    localparam logic signed [MAG_W-1:0] MAG_MAX = 24'sh7FFFFF;
    localparam logic signed [MAG_W-1:0] MAG_MIN = 24'sh800000;

    // Operation codes.
    typedef enum logic [3:0] {
        FUNC_ADD   = 4'd0,
        FUNC_SUB   = 4'd1,
        FUNC_MUL   = 4'd2,
        FUNC_DIV   = 4'd3,
        FUNC_ADD_S = 4'd4,
        FUNC_SUB_S = 4'd5,
        FUNC_MUL_S = 4'd6,
        FUNC_DIV_S = 4'd7,
        FUNC_S_SUB = 4'd8,
        FUNC_S_DIV = 4'd9
    } t_func;

    // Side information that travels with a transaction through the divider.
    typedef struct packed {
        logic             is_div;
        logic             dz;
        logic             neg;
        logic             dd_neg;
        logic [ANG_W-1:0] ang;
    } t_md_side;

    // Arctangent of 2^-idx as a 32-bit fraction of a full turn.
    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: design/pca_delay.sv
// Fixed-depth register delay line with synchronous clear.
`timescale 1ns / 1ps

module pca_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_tap [DEPTH];

    // Shift the taps every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_tap[k] <= '0;
            end
        end else begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

FILE: design/pca_rotate.sv
// Pipelined CORDIC rotation: polar magnitude and angle to Cartesian x and y.
`timescale 1ns / 1ps

module pca_rotate #(
    parameter int STAGES = 16
) (
    input  logic                                i_clk,
    input  logic signed [pca_pkg::MAG_W-1:0]   i_mag,
    input  logic        [pca_pkg::ANG_W-1:0]   i_ang,
    output logic signed [pca_pkg::XW-1:0]      o_x,
    output logic signed [pca_pkg::XW-1:0]      o_y
);

    localparam int XW = pca_pkg::XW;
    localparam int ZW = pca_pkg::ZW;
    localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1 <<< 30);
    localparam logic signed [ZW-1:0] HALF    = ZW'(64'sd1 <<< 31);

    logic signed [55:0]   r_prod;
    logic [pca_pkg::ANG_W-1:0] r_ang;
    logic signed [XW-1:0] r_x [STAGES+1];
    logic signed [XW-1:0] r_y [STAGES+1];
    logic signed [ZW-1:0] r_z [STAGES];

    logic signed [XW-1:0] n_x0;
    logic signed [ZW-1:0] n_z0;
    logic signed [ZW-1:0] z_raw;

    // Gain correction applied up front.
    always_ff @(posedge i_clk) begin
        r_prod <= i_mag * $signed({1'b0, pca_pkg::GAIN_Q30});
        r_ang  <= i_ang;
    end

    // Floor the scaled magnitude and fold the angle into the right half plane.
    always_comb begin
        z_raw = $signed({{(ZW-32){r_ang[pca_pkg::ANG_W-1]}}, r_ang, 16'b0});
        n_x0  = XW'($signed(r_prod[55:30-pca_pkg::FRAME_GUARD]));
        n_z0  = z_raw;
        if (z_raw > QUARTER) begin
            n_x0 = -n_x0;
            n_z0 = z_raw - HALF;
        end else if (z_raw < -QUARTER) begin
            n_x0 = -n_x0;
            n_z0 = z_raw + HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= n_x0;
        r_y[0] <= '0;
        r_z[0] <= n_z0;
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN = $signed({{(ZW-32){1'b0}},
                                                        pca_pkg::atan_turn(i)});
        always_ff @(posedge i_clk) begin
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
            end
        end
        if (i < STAGES - 1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (r_z[i] >= 0) begin
                    r_z[i+1] <= r_z[i] - ATAN;
                end else begin
                    r_z[i+1] <= r_z[i] + ATAN;
                end
            end
        end
    end

    assign o_x = r_x[STAGES];
    assign o_y = r_y[STAGES];

endmodule

FILE: design/pca_vector.sv
// Cartesian combine, pipelined CORDIC vectoring and gain correction back to polar form.
`timescale 1ns / 1ps

module pca_vector #(
    parameter int STAGES = 16
) (
    input  logic                              i_clk,
    input  logic [3:0]                        i_func,
    input  logic signed [pca_pkg::XW-1:0]     i_ax,
    input  logic signed [pca_pkg::XW-1:0]     i_ay,
    input  logic signed [pca_pkg::XW-1:0]     i_bx,
    input  logic signed [pca_pkg::XW-1:0]     i_by,
    input  logic signed [pca_pkg::XW-1:0]     i_sx,
    output logic signed [pca_pkg::MAG_W-1:0]  o_mag,
    output logic [pca_pkg::ANG_W-1:0]         o_ang
);

    localparam int VW = pca_pkg::VW;
    localparam int ZW = pca_pkg::ZW;
    localparam int SPLIT = 17;
    localparam int HW = VW - 1 - SPLIT;
    localparam logic signed [ZW-1:0] HALF = ZW'(64'sd1 <<< 31);
    localparam logic [67:0] MRND = 68'd1 << (29 + pca_pkg::FRAME_GUARD);

    logic signed [VW-1:0] ax, ay, bx, by, sx;
    logic signed [VW-1:0] n_cx, n_cy;
    logic signed [VW-1:0] r_cx, r_cy;

    logic signed [VW-1:0] r_x [STAGES+1];
    logic signed [VW-1:0] r_y [STAGES+1];
    logic signed [ZW-1:0] r_z [STAGES+1];
    logic                 r_zr [STAGES+1];

    logic [VW-2:0]        xc;
    logic [HW+29:0]       r_ph;
    logic [SPLIT+29:0]    r_pl;
    logic                 r_gzero;
    logic [pca_pkg::ANG_W-1:0] r_gang;
    logic signed [ZW-1:0] zrnd;

    logic [67:0]          msum;
    logic [29:0]          mval;

    always_comb begin
        ax = VW'(i_ax);
        ay = VW'(i_ay);
        bx = VW'(i_bx);
        by = VW'(i_by);
        sx = VW'(i_sx);
    end

    // Combine the operands in Cartesian form.
    always_comb begin
        case (i_func)
            pca_pkg::FUNC_ADD: begin
                n_cx = ax + bx;
                n_cy = ay + by;
            end
            pca_pkg::FUNC_SUB: begin
                n_cx = ax - bx;
                n_cy = ay - by;
            end
            pca_pkg::FUNC_ADD_S: begin
                n_cx = ax + sx;
                n_cy = ay;
            end
            pca_pkg::FUNC_SUB_S: begin
                n_cx = ax - sx;
                n_cy = ay;
            end
            pca_pkg::FUNC_S_SUB: begin
                n_cx = sx - ax;
                n_cy = -ay;
            end
            default: begin
                n_cx = '0;
                n_cy = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cx <= n_cx;
        r_cy <= n_cy;
    end

    // Move the vector into the right half plane and flag the zero vector.
    always_ff @(posedge i_clk) begin
        r_zr[0] <= (r_cx == '0) && (r_cy == '0);
        if (r_cx < 0) begin
            r_x[0] <= -r_cx;
            r_y[0] <= -r_cy;
            r_z[0] <= HALF;
        end else begin
            r_x[0] <= r_cx;
            r_y[0] <= r_cy;
            r_z[0] <= '0;
        end
    end

    // One vectoring step per stage drives y toward zero.
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN = $signed({{(ZW-32){1'b0}},
                                                        pca_pkg::atan_turn(i)});
        always_ff @(posedge i_clk) begin
            r_zr[i+1] <= r_zr[i];
            if (r_y[i] >= 0) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + ATAN;
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - ATAN;
            end
        end
    end

    // Gain correction as two partial products over the split magnitude.
    always_comb begin
        xc   = (r_x[STAGES] < 0) ? '0 : r_x[STAGES][VW-2:0];
        zrnd = r_z[STAGES] + ZW'(32768);
    end

    always_ff @(posedge i_clk) begin
        r_ph    <= xc[VW-2:SPLIT] * pca_pkg::GAIN_Q30;
        r_pl    <= xc[SPLIT-1:0] * pca_pkg::GAIN_Q30;
        r_gzero <= r_zr[STAGES];
        r_gang  <= zrnd[31:16];
    end

    // Round the magnitude half up and saturate it.
    always_comb begin
        msum = ({(68 - HW - 30)'(0), r_ph} << SPLIT)
             + {(68 - SPLIT - 30)'(0), r_pl} + MRND;
        mval = msum[67:38];
    end

    always_ff @(posedge i_clk) begin
        if (r_gzero) begin
            o_mag <= '0;
            o_ang <= '0;
        end else begin
            o_mag <= (mval > 30'(pca_pkg::MAG_MAX)) ? pca_pkg::MAG_MAX
                                                    : $signed(mval[pca_pkg::MAG_W-1:0]);
            o_ang <= r_gang;
        end
    end

endmodule

FILE: design/pca_muldiv.sv
// Magnitude multiply and pipelined restoring divide with angle sum or difference.
`timescale 1ns / 1ps

module pca_muldiv #(
    parameter int FRAC = 16
) (
    input  logic                              i_clk,
    input  logic [3:0]                        i_func,
    input  logic signed [pca_pkg::MAG_W-1:0]  i_a_mag,
    input  logic [pca_pkg::ANG_W-1:0]         i_a_angle,
    input  logic signed [pca_pkg::MAG_W-1:0]  i_b_mag,
    input  logic [pca_pkg::ANG_W-1:0]         i_b_angle,
    input  logic signed [pca_pkg::MAG_W-1:0]  i_scalar,
    output logic signed [pca_pkg::MAG_W-1:0]  o_mag,
    output logic [pca_pkg::ANG_W-1:0]         o_ang,
    output logic                              o_dz
);

    localparam int MW = pca_pkg::MAG_W;
    localparam int N  = MW + FRAC;
    localparam int PW = 2 * MW;
    localparam logic signed [PW:0] RND = (PW+1)'(1) <<< (FRAC - 1);
    localparam logic [N-1:0] Q_LIM_NEG = N'(1) << (MW - 1);
    localparam logic [N-1:0] Q_LIM_POS = Q_LIM_NEG - N'(1);

    logic signed [MW-1:0] dd, dv, m1, m2;
    logic [MW-1:0]        dd_abs, dv_abs;
    pca_pkg::t_md_side    n_side;

    logic [MW-1:0]        r_rem  [N+1];
    logic [N-1:0]         r_rq   [N+1];
    logic [MW-1:0]        r_den  [N+1];
    pca_pkg::t_md_side    r_side [N+1];
    logic signed [PW-1:0] r_prod [N+1];

    logic [N-1:0]         q;
    logic signed [PW:0]   prnd;
    logic signed [PW:0]   pshift;
    logic signed [MW-1:0] mul_mag, div_mag;

    // Pick operands and the result angle for the operation.
    always_comb begin
        dd     = i_a_mag;
        dv     = i_b_mag;
        m1     = i_a_mag;
        m2     = i_b_mag;
        n_side = '0;
        case (i_func)
            pca_pkg::FUNC_MUL: begin
                n_side.ang = i_a_angle + i_b_angle;
            end
            pca_pkg::FUNC_MUL_S: begin
                m2         = i_scalar;
                n_side.ang = i_a_angle;
            end
            pca_pkg::FUNC_DIV: begin
                n_side.is_div = 1'b1;
                n_side.ang    = i_a_angle - i_b_angle;
            end
            pca_pkg::FUNC_DIV_S: begin
                n_side.is_div = 1'b1;
                dv            = i_scalar;
                n_side.ang    = i_a_angle;
            end
            pca_pkg::FUNC_S_DIV: begin
                n_side.is_div = 1'b1;
                dd            = i_scalar;
                dv            = i_a_mag;
                n_side.ang    = -i_a_angle;
            end
            default: begin
                n_side.ang = '0;
            end
        endcase
        n_side.dz     = n_side.is_div && (dv == '0);
        n_side.neg    = dd[MW-1] ^ dv[MW-1];
        n_side.dd_neg = dd[MW-1];
        dd_abs        = dd[MW-1] ? MW'(-dd) : MW'(dd);
        dv_abs        = dv[MW-1] ? MW'(-dv) : MW'(dv);
    end

    // Input stage: magnitudes of the division operands and the full product.
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_rq[0]   <= {dd_abs, {FRAC{1'b0}}};
        r_den[0]  <= dv_abs;
        r_side[0] <= n_side;
        r_prod[0] <= m1 * m2;
    end

    // One quotient bit per stage.
    for (genvar k = 0; k < N; k++) begin : g_div
        logic [MW:0] trial;
        assign trial = {r_rem[k], r_rq[k][N-1]};
        always_ff @(posedge i_clk) begin
            r_den[k+1]  <= r_den[k];
            r_side[k+1] <= r_side[k];
            r_prod[k+1] <= r_prod[k];
            if (trial >= {1'b0, r_den[k]}) begin
                r_rem[k+1] <= MW'(trial - {1'b0, r_den[k]});
                r_rq[k+1]  <= {r_rq[k][N-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= trial[MW-1:0];
                r_rq[k+1]  <= {r_rq[k][N-2:0], 1'b0};
            end
        end
    end

    // Round and saturate the product; sign and saturate the truncated quotient.
    always_comb begin
        q      = r_rq[N];
        prnd   = $signed({r_prod[N][PW-1], r_prod[N]}) + RND;
        pshift = prnd >>> FRAC;
        if (pshift > (PW+1)'(pca_pkg::MAG_MAX)) begin
            mul_mag = pca_pkg::MAG_MAX;
        end else if (pshift < (PW+1)'(pca_pkg::MAG_MIN)) begin
            mul_mag = pca_pkg::MAG_MIN;
        end else begin
            mul_mag = pshift[MW-1:0];
        end
        if (r_side[N].dz) begin
            div_mag = r_side[N].dd_neg ? pca_pkg::MAG_MIN : pca_pkg::MAG_MAX;
        end else if (r_side[N].neg) begin
            div_mag = (q > Q_LIM_NEG) ? pca_pkg::MAG_MIN : $signed(-q[MW-1:0]);
        end else begin
            div_mag = (q > Q_LIM_POS) ? pca_pkg::MAG_MAX : $signed(q[MW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        o_mag <= r_side[N].is_div ? div_mag : mul_mag;
        o_ang <= r_side[N].ang;
        o_dz  <= r_side[N].dz;
    end

endmodule

FILE: design/polar_complex_alu_top.sv
// Top level of the polar complex ALU: input stage, CORDIC and multiply/divide engines.
`timescale 1ns / 1ps

// Usage:
// A transaction enters when start is high at a rising edge; busy is always low,
// so one transaction can enter in every cycle. The operands are the function
// code, two polar operands (magnitude and binary angle) and a real scalar.
// Each transaction yields exactly one result, shown on o_mag_out, o_angle_out
// and o_divide_by_zero for a single cycle while o_valid is high; the receiver
// cannot stall it and must take it in that cycle.
// All functions take the same path: both engines and the control are delayed
// to match the longer of the rotate-plus-vectoring CORDIC chain and the
// bit-per-stage divider.
// Throughput is one transaction per cycle. Results leave in entry order.
// Synchronous reset clears all valid bits; no result appears from a
// transaction that was in flight at reset.
module polar_complex_alu_top #(
    parameter int CORDIC_STAGES = 16,
    parameter int MAG_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [3:0]                        i_func,
    input  logic signed [pca_pkg::MAG_W-1:0]  i_a_mag,
    input  logic [pca_pkg::ANG_W-1:0]         i_a_angle,
    input  logic signed [pca_pkg::MAG_W-1:0]  i_b_mag,
    input  logic [pca_pkg::ANG_W-1:0]         i_b_angle,
    input  logic signed [pca_pkg::MAG_W-1:0]  i_scalar_in,
    output logic                              o_valid,
    output logic signed [pca_pkg::MAG_W-1:0]  o_mag_out,
    output logic [pca_pkg::ANG_W-1:0]         o_angle_out,
    output logic                              o_divide_by_zero
);

    localparam int MW = pca_pkg::MAG_W;
    localparam int AW = pca_pkg::ANG_W;
    localparam int XW = pca_pkg::XW;
    localparam int LROT = CORDIC_STAGES + 2;
    localparam int LC = 2 * CORDIC_STAGES + 6;
    localparam int LD = MW + MAG_FRAC_BITS + 2;
    localparam int L  = ((LC > LD) ? LC : LD) + 1;

    logic                 r_v0;
    logic [3:0]           r_func;
    logic signed [MW-1:0] r_a_mag, r_b_mag, r_scalar;
    logic [AW-1:0]        r_a_ang, r_b_ang;

    logic signed [XW-1:0] ax, ay, bx, by, sx0;
    logic [XW-1:0]        sx_d;
    logic [3:0]           func_rot;
    logic signed [MW-1:0] c_mag, md_mag;
    logic [AW-1:0]        c_ang, md_ang;
    logic                 md_dz;
    logic [MW+AW-1:0]     c_res;
    logic [MW+AW:0]       md_res;
    logic [3:0]           func_l;
    logic                 v_l;

    logic                 r_valid;
    logic signed [MW-1:0] r_mag;
    logic [AW-1:0]        r_ang;
    logic                 r_dz;
    logic signed [MW-1:0] n_mag;
    logic [AW-1:0]        n_ang;
    logic                 n_dz;

    assign busy = 1'b0;

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
        r_func   <= i_func;
        r_a_mag  <= i_a_mag;
        r_a_ang  <= i_a_angle;
        r_b_mag  <= i_b_mag;
        r_b_ang  <= i_b_angle;
        r_scalar <= i_scalar_in;
    end

    // Polar to Cartesian for both operands.
    pca_rotate #(.STAGES(CORDIC_STAGES)) u_rot_a (
        .i_clk (i_clk),
        .i_mag (r_a_mag),
        .i_ang (r_a_ang),
        .o_x   (ax),
        .o_y   (ay)
    );

    pca_rotate #(.STAGES(CORDIC_STAGES)) u_rot_b (
        .i_clk (i_clk),
        .i_mag (r_b_mag),
        .i_ang (r_b_ang),
        .o_x   (bx),
        .o_y   (by)
    );

    // The scalar in the Cartesian frame, and the code, kept in step with rotation.
    assign sx0 = $signed({{(XW - MW - pca_pkg::FRAME_GUARD){r_scalar[MW-1]}},
                          r_scalar, {pca_pkg::FRAME_GUARD{1'b0}}});

    pca_delay #(.W(XW + 4), .DEPTH(LROT)) u_dly_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     ({sx0, r_func}),
        .o_q     ({sx_d, func_rot})
    );

    pca_vector #(.STAGES(CORDIC_STAGES)) u_vec (
        .i_clk  (i_clk),
        .i_func (func_rot),
        .i_ax   (ax),
        .i_ay   (ay),
        .i_bx   (bx),
        .i_by   (by),
        .i_sx   ($signed(sx_d)),
        .o_mag  (c_mag),
        .o_ang  (c_ang)
    );

    pca_muldiv #(.FRAC(MAG_FRAC_BITS)) u_md (
        .i_clk     (i_clk),
        .i_func    (r_func),
        .i_a_mag   (r_a_mag),
        .i_a_angle (r_a_ang),
        .i_b_mag   (r_b_mag),
        .i_b_angle (r_b_ang),
        .i_scalar  (r_scalar),
        .o_mag     (md_mag),
        .o_ang     (md_ang),
        .o_dz      (md_dz)
    );

    // Align both engines and the control to a common latency.
    pca_delay #(.W(MW + AW), .DEPTH(L - LC)) u_dly_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     ({c_mag, c_ang}),
        .o_q     (c_res)
    );

    pca_delay #(.W(MW + AW + 1), .DEPTH(L - LD)) u_dly_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     ({md_mag, md_ang, md_dz}),
        .o_q     (md_res)
    );

    pca_delay #(.W(5), .DEPTH(L)) u_dly_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     ({r_v0, r_func}),
        .o_q     ({v_l, func_l})
    );

    // Pick the engine that serves the operation.
    always_comb begin
        n_mag = '0;
        n_ang = '0;
        n_dz  = 1'b0;
        case (func_l)
            pca_pkg::FUNC_ADD, pca_pkg::FUNC_SUB, pca_pkg::FUNC_ADD_S,
            pca_pkg::FUNC_SUB_S, pca_pkg::FUNC_S_SUB: begin
                n_mag = $signed(c_res[MW+AW-1:AW]);
                n_ang = c_res[AW-1:0];
            end
            pca_pkg::FUNC_MUL, pca_pkg::FUNC_DIV, pca_pkg::FUNC_MUL_S,
            pca_pkg::FUNC_DIV_S, pca_pkg::FUNC_S_DIV: begin
                n_mag = $signed(md_res[MW+AW:AW+1]);
                n_ang = md_res[AW:1];
                n_dz  = md_res[0];
            end
            default: begin
                n_mag = '0;
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dz    <= 1'b0;
        end else begin
            r_valid <= v_l;
            r_dz    <= v_l && n_dz;
        end
        r_mag <= n_mag;
        r_ang <= n_ang;
    end

    assign o_valid          = r_valid;
    assign o_mag_out        = r_mag;
    assign o_angle_out      = r_ang;
    assign o_divide_by_zero = r_dz;

endmodule

FILE: design/pca_checker.sv
// Port-level checker for the polar complex ALU and its bind to the top level.
`timescale 1ns / 1ps

module pca_checker #(
    parameter int CORDIC_STAGES = 16,
    parameter int MAG_FRAC_BITS = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_valid,
    input logic signed [pca_pkg::MAG_W-1:0]  o_mag_out,
    input logic                              o_divide_by_zero
);

    localparam int LC  = 2 * CORDIC_STAGES + 6;
    localparam int LD  = pca_pkg::MAG_W + MAG_FRAC_BITS + 2;
    localparam int LAT = ((LC > LD) ? LC : LD) + 3;

    // The block never refuses a transaction.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // Every result comes from a transaction accepted a fixed time earlier.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without matching transaction");

    // Reset leaves no result behind.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result right after reset");

    // A divide-by-zero flag marks a saturated magnitude on a valid result.
    a_dz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_divide_by_zero |-> (o_valid && (o_mag_out == pca_pkg::MAG_MAX
                                          || o_mag_out == pca_pkg::MAG_MIN)))
        else $error("divide-by-zero flag without saturated result");

endmodule

bind polar_complex_alu_top pca_checker #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .MAG_FRAC_BITS (MAG_FRAC_BITS)
) u_pca_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_mag_out        (o_mag_out),
    .o_divide_by_zero (o_divide_by_zero)
);

FILE: test/tb_top.sv
// Self-checking testbench for the polar complex ALU with a built-in result predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int STAGES     = 16;
    localparam int FRAC       = 16;
    localparam int LATENCY    = 45;
    localparam int IDLE_LIMIT = 4000;
    localparam int RAND_ITEMS = 175;

    typedef struct packed {
        logic signed [pca_pkg::MAG_W-1:0] mag;
        logic [pca_pkg::ANG_W-1:0]        ang;
        logic                             dz;
    } t_polar_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic [3:0]                       i_func = pca_pkg::FUNC_ADD;
    logic signed [pca_pkg::MAG_W-1:0] i_a_mag = '0;
    logic [pca_pkg::ANG_W-1:0]        i_a_angle = '0;
    logic signed [pca_pkg::MAG_W-1:0] i_b_mag = '0;
    logic [pca_pkg::ANG_W-1:0]        i_b_angle = '0;
    logic signed [pca_pkg::MAG_W-1:0] i_scalar_in = '0;
    logic                             o_valid;
    logic signed [pca_pkg::MAG_W-1:0] o_mag_out;
    logic [pca_pkg::ANG_W-1:0]        o_angle_out;
    logic                             o_divide_by_zero;

    t_polar_result pending_results[$];
    int            error_count = 0;
    int            sent_count = 0;
    int            checked_count = 0;
    int            zero_div_count = 0;
    int            idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    polar_complex_alu_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_a_mag          (i_a_mag),
        .i_a_angle        (i_a_angle),
        .i_b_mag          (i_b_mag),
        .i_b_angle        (i_b_angle),
        .i_scalar_in      (i_scalar_in),
        .o_valid          (o_valid),
        .o_mag_out        (o_mag_out),
        .o_angle_out      (o_angle_out),
        .o_divide_by_zero (o_divide_by_zero)
    );

    // Clamp a wide value into the 24-bit magnitude range.
    function automatic longint clamp_mag(input longint v);
        if (v > longint'(pca_pkg::MAG_MAX)) return longint'(pca_pkg::MAG_MAX);
        if (v < longint'(pca_pkg::MAG_MIN)) return longint'(pca_pkg::MAG_MIN);
        return v;
    endfunction

    // CORDIC rotation of a polar number into the guarded Cartesian frame.
    function automatic void rotate_to_xy(input longint mag, input longint ang,
                                         output longint xo, output longint yo);
        longint x, y, z, dx, dy;
        x = (mag * longint'(pca_pkg::GAIN_Q30)) >>> (30 - pca_pkg::FRAME_GUARD);
        y = 0;
        z = (ang & 64'hFFFF) << 16;
        if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
        if (z > (64'sd1 <<< 30)) begin
            x = -x;
            z -= (64'sd1 <<< 31);
        end else if (z < -(64'sd1 <<< 30)) begin
            x = -x;
            z += (64'sd1 <<< 31);
        end
        for (int i = 0; i < STAGES && i < pca_pkg::ATAN_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(pca_pkg::atan_turn(i));
            end else begin
                x += dx; y -= dy; z += longint'(pca_pkg::atan_turn(i));
            end
        end
        xo = x;
        yo = y;
    endfunction

    // CORDIC vectoring of a Cartesian point back to magnitude and angle.
    function automatic void vector_to_polar(input longint xi, input longint yi,
                                            output longint mag, output longint ang);
        longint x, y, z, dx, dy;
        longint unsigned m;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0) begin
            mag = 0;
            ang = 0;
            return;
        end
        if (x < 0) begin
            x = -x; y = -y; z = 64'sd1 <<< 31;
        end
        for (int i = 0; i < STAGES && i < pca_pkg::ATAN_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(pca_pkg::atan_turn(i));
            end else begin
                x -= dx; y += dy; z -= longint'(pca_pkg::atan_turn(i));
            end
        end
        if (x < 0) x = 0;
        m = (unsigned'(x) * 64'(pca_pkg::GAIN_Q30)
             + (64'd1 << (29 + pca_pkg::FRAME_GUARD))) >> (30 + pca_pkg::FRAME_GUARD);
        mag = (m > 64'd8388607) ? longint'(pca_pkg::MAG_MAX) : longint'(m);
        ang = ((z + (64'sd1 <<< 33) + 32768) >>> 16) & 64'hFFFF;
    endfunction

    // Rounded fixed-point product of two magnitudes.
    function automatic longint scale_product(input longint a, input longint b);
        return clamp_mag((a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
    endfunction

    // Truncated fixed-point quotient; a zero divisor saturates and flags.
    function automatic longint scale_quotient(input longint a, input longint b,
                                              inout logic dz);
        if (b == 0) begin
            dz = 1'b1;
            return (a >= 0) ? longint'(pca_pkg::MAG_MAX) : longint'(pca_pkg::MAG_MIN);
        end
        return clamp_mag((a * (64'sd1 <<< FRAC)) / b);
    endfunction

    // Expected result of one transaction.
    function automatic t_polar_result predict_polar_op(
        input logic [3:0] func, input logic signed [pca_pkg::MAG_W-1:0] am,
        input logic [pca_pkg::ANG_W-1:0] aa, input logic signed [pca_pkg::MAG_W-1:0] bm,
        input logic [pca_pkg::ANG_W-1:0] ba, input logic signed [pca_pkg::MAG_W-1:0] s);
        t_polar_result r;
        longint mag, ang, ax, ay, bx, by, sx;
        logic dz;
        mag = 0;
        ang = 0;
        dz = 1'b0;
        sx = longint'(s) * (64'sd1 <<< pca_pkg::FRAME_GUARD);
        case (func)
            pca_pkg::FUNC_ADD, pca_pkg::FUNC_SUB: begin
                rotate_to_xy(am, aa, ax, ay);
                rotate_to_xy(bm, ba, bx, by);
                if (func == pca_pkg::FUNC_ADD) vector_to_polar(ax + bx, ay + by, mag, ang);
                else                           vector_to_polar(ax - bx, ay - by, mag, ang);
            end
            pca_pkg::FUNC_MUL: begin
                mag = scale_product(am, bm); ang = aa + ba;
            end
            pca_pkg::FUNC_DIV: begin
                mag = scale_quotient(am, bm, dz); ang = aa + 65536 - ba;
            end
            pca_pkg::FUNC_ADD_S, pca_pkg::FUNC_SUB_S, pca_pkg::FUNC_S_SUB: begin
                rotate_to_xy(am, aa, ax, ay);
                if (func == pca_pkg::FUNC_ADD_S)
                    vector_to_polar(ax + sx, ay, mag, ang);
                else if (func == pca_pkg::FUNC_SUB_S)
                    vector_to_polar(ax - sx, ay, mag, ang);
                else
                    vector_to_polar(sx - ax, -ay, mag, ang);
            end
            pca_pkg::FUNC_MUL_S: begin
                mag = scale_product(am, s); ang = aa;
            end
            pca_pkg::FUNC_DIV_S: begin
                mag = scale_quotient(am, s, dz); ang = aa;
            end
            pca_pkg::FUNC_S_DIV: begin
                mag = scale_quotient(s, am, dz); ang = 65536 - aa;
            end
            default: ;
        endcase
        r.mag = mag[pca_pkg::MAG_W-1:0];
        r.ang = ang[pca_pkg::ANG_W-1:0];
        r.dz  = dz;
        return r;
    endfunction

    // Record each accepted transaction and check each result against the oldest one.
    always @(posedge i_clk) begin
        t_polar_result want;
        if (i_rst_n) begin
            if (o_valid || (start && !busy)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (o_valid) begin
                checked_count <= checked_count + 1;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result mag=%0d ang=%0d dz=%0b", $time,
                             o_mag_out, o_angle_out, o_divide_by_zero);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_mag_out !== want.mag) begin
                        $display("%0t: mag_out expected %0d actual %0d", $time,
                                 want.mag, o_mag_out);
                        error_count++;
                    end
                    if (o_angle_out !== want.ang) begin
                        $display("%0t: angle_out expected %0d actual %0d", $time,
                                 want.ang, o_angle_out);
                        error_count++;
                    end
                    if (o_divide_by_zero !== want.dz) begin
                        $display("%0t: divide_by_zero expected %0b actual %0b", $time,
                                 want.dz, o_divide_by_zero);
                        error_count++;
                    end
                end
            end
            if (start && !busy) begin
                want = predict_polar_op(i_func, i_a_mag, i_a_angle, i_b_mag,
                                        i_b_angle, i_scalar_in);
                if (want.dz) zero_div_count++;
                pending_results.push_back(want);
                sent_count++;
            end
        end
    end

    // Watchdog on cycles with no transaction in either direction.
    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout with %0d results outstanding", pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Random gap: mostly none or short, a few long.
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Magnitude with weight on the extremes, zero and small values.
    function automatic logic signed [pca_pkg::MAG_W-1:0] pick_mag();
        case ($urandom_range(0, 9))
            0: return pca_pkg::MAG_MAX;
            1: return pca_pkg::MAG_MIN;
            2: return '0;
            3: return pca_pkg::MAG_W'($urandom_range(0, 8)) - 24'sd4;
            4: return 24'sh010000;
            5: return -24'sh010000;
            6: return pca_pkg::MAG_W'($urandom_range(0, 32'h3FFFF)) - 24'sh20000;
            default: return pca_pkg::MAG_W'($urandom());
        endcase
    endfunction

    function automatic logic [pca_pkg::ANG_W-1:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'hFFFF;
            2: return pca_pkg::ANG_W'(16'h4000 * $urandom_range(0, 3));
            default: return pca_pkg::ANG_W'($urandom());
        endcase
    endfunction

    // Drive one transaction and hold it until it is taken, then idle for a gap.
    task automatic send_polar_op(input logic [3:0] func,
                                 input logic signed [pca_pkg::MAG_W-1:0] am,
                                 input logic [pca_pkg::ANG_W-1:0] aa,
                                 input logic signed [pca_pkg::MAG_W-1:0] bm,
                                 input logic [pca_pkg::ANG_W-1:0] ba,
                                 input logic signed [pca_pkg::MAG_W-1:0] s, input int gap);
        @(negedge i_clk);
        start = 1'b1;
        i_func = func;
        i_a_mag = am;
        i_a_angle = aa;
        i_b_mag = bm;
        i_b_angle = ba;
        i_scalar_in = s;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_random_op(input logic [3:0] func, input int gap);
        send_polar_op(func, pick_mag(), pick_angle(), pick_mag(), pick_angle(),
                      pick_mag(), gap);
    endtask

    task automatic idle_line();
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Extremes, every operation, zero divisors, zero vectors, unused codes.
    task automatic test_directed();
        send_polar_op(pca_pkg::FUNC_ADD, pca_pkg::MAG_MAX, 16'h0000, pca_pkg::MAG_MAX,
                      16'h0000, '0, 0);
        send_polar_op(pca_pkg::FUNC_ADD, pca_pkg::MAG_MIN, 16'hFFFF, pca_pkg::MAG_MAX,
                      16'h8000, '0, 0);
        send_polar_op(pca_pkg::FUNC_SUB, 24'sh123456, 16'h2345, 24'sh123456, 16'h2345,
                      '0, 0);
        send_polar_op(pca_pkg::FUNC_SUB, pca_pkg::MAG_MAX, 16'h4000, pca_pkg::MAG_MIN,
                      16'hC000, '0, 1);
        send_polar_op(pca_pkg::FUNC_MUL, pca_pkg::MAG_MAX, 16'hFFFF, pca_pkg::MAG_MAX,
                      16'hFFFF, '0, 0);
        send_polar_op(pca_pkg::FUNC_MUL, pca_pkg::MAG_MIN, 16'h8000, pca_pkg::MAG_MAX,
                      16'h8000, '0, 0);
        send_polar_op(pca_pkg::FUNC_DIV, 24'sh030000, 16'h1000, '0, 16'h2000, '0, 0);
        send_polar_op(pca_pkg::FUNC_DIV, -24'sh030000, 16'h1000, '0, 16'hFFFF, '0, 0);
        send_polar_op(pca_pkg::FUNC_DIV, '0, 16'h0000, '0, 16'h0001, '0, 0);
        send_polar_op(pca_pkg::FUNC_DIV, pca_pkg::MAG_MIN, 16'h0000, 24'sd1, 16'h0000,
                      '0, 2);
        send_polar_op(pca_pkg::FUNC_ADD_S, '0, 16'h1234, '0, '0, '0, 0);
        send_polar_op(pca_pkg::FUNC_ADD_S, pca_pkg::MAG_MAX, 16'h0000, '0, '0,
                      pca_pkg::MAG_MAX, 0);
        send_polar_op(pca_pkg::FUNC_SUB_S, 24'sh010000, 16'h0000, '0, '0, 24'sh010000, 0);
        send_polar_op(pca_pkg::FUNC_SUB_S, pca_pkg::MAG_MIN, 16'h8000, '0, '0,
                      pca_pkg::MAG_MIN, 0);
        send_polar_op(pca_pkg::FUNC_S_SUB, pca_pkg::MAG_MAX, 16'hC000, '0, '0,
                      pca_pkg::MAG_MIN, 0);
        send_polar_op(pca_pkg::FUNC_MUL_S, pca_pkg::MAG_MIN, 16'hFFFF, '0, '0,
                      pca_pkg::MAG_MIN, 0);
        send_polar_op(pca_pkg::FUNC_MUL_S, -24'sh008000, 16'h0001, '0, '0, 24'sh008000, 0);
        send_polar_op(pca_pkg::FUNC_DIV_S, pca_pkg::MAG_MAX, 16'h7FFF, '0, '0, '0, 0);
        send_polar_op(pca_pkg::FUNC_DIV_S, pca_pkg::MAG_MIN, 16'h7FFF, '0, '0, -24'sd1, 0);
        send_polar_op(pca_pkg::FUNC_S_DIV, '0, 16'h0000, '0, '0, -24'sd5, 0);
        send_polar_op(pca_pkg::FUNC_S_DIV, 24'sd1, 16'hFFFF, '0, '0, pca_pkg::MAG_MAX, 0);
        for (int code = pca_pkg::FUNC_S_DIV + 1; code < 16; code++)
            send_polar_op(4'(code), pca_pkg::MAG_MAX, 16'hFFFF, pca_pkg::MAG_MIN, 16'hFFFF,
                          pca_pkg::MAG_MIN, 0);
        idle_line();
    endtask

    // Cartesian operations through the CORDIC path.
    task automatic test_cordic_ops();
        logic [3:0] ops [5] = '{pca_pkg::FUNC_ADD, pca_pkg::FUNC_SUB, pca_pkg::FUNC_ADD_S,
                                pca_pkg::FUNC_SUB_S, pca_pkg::FUNC_S_SUB};
        for (int n = 0; n < RAND_ITEMS; n++)
            send_random_op(ops[$urandom_range(0, 4)], pick_gap());
        idle_line();
    endtask

    // Multiply and divide forms; zero divisors come from the weighted magnitude picks.
    task automatic test_mul_div_ops();
        logic [3:0] ops [5] = '{pca_pkg::FUNC_MUL, pca_pkg::FUNC_DIV, pca_pkg::FUNC_MUL_S,
                                pca_pkg::FUNC_DIV_S, pca_pkg::FUNC_S_DIV};
        for (int n = 0; n < RAND_ITEMS; n++)
            send_random_op(ops[$urandom_range(0, 4)], pick_gap());
        idle_line();
    endtask

    // All function codes back to back and with gaps.
    task automatic test_mixed_ops();
        for (int n = 0; n < RAND_ITEMS; n++)
            send_random_op(($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                         : 4'($urandom_range(0, 9)),
                           (n % 60 < 20) ? 0 : pick_gap());
        idle_line();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_cordic_ops();
        test_mul_div_ops();
        test_mixed_ops();
        wait (pending_results.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d transactions, checked %0d results (%0d zero divisors).",
                 sent_count, checked_count, zero_div_count);
        $display("Covered all ten operations, unused codes, extremes and random idle gaps.");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
